@@ rtl/sfir_pkg.sv @@
// Shared types and constants for the stereo FIR filter.
// Used by sfir_hist_mem, sfir_mac and stereo_fir_filter_top; no dependencies.
package sfir_pkg;

  // Field widths fixed by the data format
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned PROD_W     = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W      = PROD_W + 3;       // room for seven products
  localparam int unsigned FRAC_W     = 12;               // Q4.12 coefficients
  localparam int unsigned TAP_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned HIST_SLOTS = 8;                // history slots per channel
  localparam int unsigned SLOT_W     = 3;

  // Coefficient value 1.0 in Q4.12
  localparam logic signed [COEF_W-1:0] COEF_ONE = 16'sd4096;
  localparam int unsigned COEF_ONE_TAPS = 4;             // taps that reset to 1.0
  localparam logic [TAP_W-1:0] TAPS_RESET = 3'd4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT = 3'd0,
    REG_COEF_0    = 3'd1
  } cfg_reg_e;

  // Control from the sequencer to the MAC unit
  typedef struct packed {
    logic clr;   // zero the accumulator and flush the product stage
    logic vld;   // operand and coefficient are valid this cycle
  } mac_ctrl_t;

  // Final filter result
  typedef struct packed {
    logic                       clipped;
    logic signed [SAMPLE_W-1:0] filtered;
  } fir_res_t;

endpackage

@@ rtl/sfir_hist_mem.sv @@
// Sample history memory: one write port, one read port, registered read data.
// Per-entry valid bits make never-written entries read as zero. Uses sfir_pkg.
module sfir_hist_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_en_i,
  input  logic [AW-1:0]                        wr_addr_i,
  input  logic signed [sfir_pkg::SAMPLE_W-1:0] wr_data_i,
  input  logic                                 rd_en_i,
  input  logic [AW-1:0]                        rd_addr_i,
  output logic signed [sfir_pkg::SAMPLE_W-1:0] rd_data_o
);
  import sfir_pkg::*;

  logic signed [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]           valid_q;
  logic signed [SAMPLE_W-1:0] rd_q;
  logic                       rd_vld_q;

  // Storage array and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // Written-since-reset marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

@@ rtl/sfir_mac.sv @@
// Multiply-accumulate unit: registered product, then accumulate; the
// accumulator is floored by 2^12 and saturated to 16 bits. Uses sfir_pkg.
module sfir_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sfir_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [sfir_pkg::SAMPLE_W-1:0] operand_i,
  input  logic signed [sfir_pkg::COEF_W-1:0]   coef_i,
  output logic                                 busy_o,
  output sfir_pkg::fir_res_t                   res_o
);
  import sfir_pkg::*;

  localparam int unsigned SH_W = ACC_W - FRAC_W;

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_v_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [SH_W-1:0]          shifted;
  logic                     ovf;

  // Product stage valid and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      acc_q    <= '0;
    end else if (ctrl_i.clr) begin
      prod_v_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      prod_v_q <= ctrl_i.vld;
      if (prod_v_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  // Product register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.vld) begin
      prod_q <= operand_i * coef_i;
    end
  end

  assign busy_o = prod_v_q;

  // Floor shift is an arithmetic drop of the fraction bits; clip when the
  // bits above the 16-bit result disagree with its sign.
  assign shifted = acc_q[ACC_W-1:FRAC_W];
  assign ovf     = (shifted[SH_W-1:SAMPLE_W-1] != '0) && (shifted[SH_W-1:SAMPLE_W-1] != '1);

  always_comb begin
    res_o.clipped = ovf;
    if (!ovf) begin
      res_o.filtered = shifted[SAMPLE_W-1:0];
    end else if (shifted[SH_W-1]) begin
      res_o.filtered = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res_o.filtered = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

@@ rtl/stereo_fir_filter_top.sv @@
// Stereo FIR filter top level: configuration registers, tap sequencer and
// output register. Uses sfir_pkg, sfir_hist_mem and sfir_mac.
//
// Each request on the input stream is one sample of one channel; it enters
// that channel's 8-slot history and produces one filtered sample on the
// output stream, the sum of coef_i times the sample i steps older, floored
// by 2^12 and saturated to 16 bits. The history lives in one memory with a
// registered read; one tap is read and multiplied per cycle by one shared
// multiplier, and the next item is taken once the current one has moved into
// the output register. Reset clears the whole history at once. Configuration
// writes take effect immediately and are meant for idle periods only.
module stereo_fir_filter_top #(
  parameter int unsigned CHANNELS = 2,
  parameter int unsigned MAX_TAPS = 7
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sfir_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sfir_pkg::COEF_W-1:0]      cfg_data_i,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,  // [15:0] sample
  input  logic [0:0]                       s_axis_tuser,  // [0] channel
  // Output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // [15:0] filtered
  output logic [1:0]                       m_axis_tuser   // [0] out_channel, [1] clipped
);
  import sfir_pkg::*;

  localparam int unsigned DEPTH = CHANNELS * HIST_SLOTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CIW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_OUT
  } state_e;

  // Configuration registers
  logic [TAP_W-1:0]         tap_count_q;
  logic signed [COEF_W-1:0] coef_q [MAX_TAPS];
  logic [CFG_IDX_W-1:0]     coef_idx;

  // Sequencer state
  state_e                   state_q, state_d;
  logic [SLOT_W-1:0]        wpos_q [CHANNELS];
  logic                     ch_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [SLOT_W-1:0]        pos_q;
  logic [TAP_W-1:0]         taps_q;
  logic [TAP_W-1:0]         i_q;
  logic                     s1_v_q;
  logic                     s1_tap0_q;
  logic signed [COEF_W-1:0] s1_coef_q;

  // Output register
  logic                     m_valid_q;
  logic                     m_chan_q;
  logic                     m_clip_q;
  logic [SAMPLE_W-1:0]      m_data_q;

  logic                     in_acc;
  logic                     ch_ok;
  logic [TAP_W-1:0]         taps_eff;
  logic                     out_free;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] operand;
  mac_ctrl_t                mac_ctrl;
  logic                     mac_busy;
  fir_res_t                 mac_res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign ch_ok         = (2'(s_axis_tuser[0]) < 2'(CHANNELS));
  assign taps_eff      = (tap_count_q > TAP_W'(MAX_TAPS)) ? TAP_W'(MAX_TAPS) : tap_count_q;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign coef_idx      = cfg_index_i - CFG_IDX_W'(REG_COEF_0);

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAPS_RESET;
      for (int k = 0; k < MAX_TAPS; k++) begin
        coef_q[k] <= (k < COEF_ONE_TAPS) ? COEF_ONE : '0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_TAP_COUNT) begin
        tap_count_q <= cfg_data_i[TAP_W-1:0];
      end else if (32'(coef_idx) < MAX_TAPS) begin
        coef_q[CIW'(coef_idx)] <= cfg_data_i;
      end
    end
  end

  // History write on acceptance; tap reads while running
  assign wr_addr = AW'({s_axis_tuser[0], wpos_q[CHW'(s_axis_tuser[0])]});
  assign rd_en   = (state_q == S_RUN) && (i_q != '0);
  assign rd_addr = AW'({ch_q, pos_q - i_q});

  sfir_hist_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc && ch_ok),
    .wr_addr_i (wr_addr),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Tap 0 is the new sample itself; older taps come from memory
  assign operand      = s1_tap0_q ? sample_q : rd_data;
  assign mac_ctrl.clr = in_acc;
  assign mac_ctrl.vld = s1_v_q;

  sfir_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mac_ctrl),
    .operand_i (operand),
    .coef_i    (s1_coef_q),
    .busy_o    (mac_busy),
    .res_o     (mac_res)
  );

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && ch_ok) begin
          state_d = (taps_eff == '0) ? S_OUT : S_RUN;
        end
      end
      S_RUN: begin
        if (i_q == taps_q - TAP_W'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!s1_v_q && !mac_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      for (int k = 0; k < CHANNELS; k++) begin
        wpos_q[k] <= '0;
      end
      i_q       <= '0;
      s1_v_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      s1_v_q  <= (state_q == S_RUN);
      if (in_acc && ch_ok) begin
        wpos_q[CHW'(s_axis_tuser[0])] <= wpos_q[CHW'(s_axis_tuser[0])] + SLOT_W'(1);
        i_q <= '0;
      end else if (state_q == S_RUN) begin
        i_q <= i_q + TAP_W'(1);
      end
      if ((state_q == S_OUT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Item payload and pipeline data
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q     <= s_axis_tuser[0];
      sample_q <= s_axis_tdata;
      pos_q    <= wpos_q[CHW'(s_axis_tuser[0])];
      taps_q   <= taps_eff;
    end
    if (state_q == S_RUN) begin
      s1_tap0_q <= (i_q == '0);
      s1_coef_q <= coef_q[CIW'(i_q)];
    end
    if ((state_q == S_OUT) && out_free) begin
      m_chan_q <= ch_q;
      m_data_q <= mac_res.filtered;
      m_clip_q <= mac_res.clipped;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = {m_clip_q, m_chan_q};

`ifndef SYNTHESIS
  // Input is only taken with the MAC pipeline empty
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!s1_v_q && !mac_busy))
    else $error("input accepted while taps still in flight");

  // A result appears only when the sequencer hands it over
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_OUT))
    else $error("output valid without a finished item");

  // Tap counter stays within the tap count while reading
  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (i_q < taps_q))
    else $error("tap index beyond tap count");

  // An accepted in-range item always leaves idle
  a_item_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ch_ok) |=> (state_q != S_IDLE))
    else $error("accepted item was dropped");
`endif

endmodule

@@ sim/stereo_fir_filter_checker.sv @@
// Scoreboard for the stereo FIR filter: tracks register writes, predicts each
// filtered sample from accepted input requests and compares the output stream.
// Depends on sfir_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module stereo_fir_filter_checker #(
  parameter int unsigned MAX_TAPS = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [sfir_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sfir_pkg::COEF_W-1:0]    cfg_data_i,
  // Input stream
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [15:0]                    s_tdata_i,   // [15:0] sample
  input  logic [0:0]                     s_tuser_i,   // [0] channel
  // Output stream
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [15:0]                    m_tdata_i,   // [15:0] filtered
  input  logic [1:0]                     m_tuser_i,   // [0] out_channel, [1] clipped
  // Status for the testbench top
  output int unsigned                    errors_o,
  output int unsigned                    pending_o,
  output int unsigned                    checked_o,
  output int unsigned                    clipped_o
);
  import sfir_pkg::*;

  typedef struct packed {
    logic                       ch;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } audio_out_t;

  // Shadow of the configuration and of the per-channel sample history
  logic [TAP_W-1:0]           taps_q;
  logic signed [COEF_W-1:0]   coef_q [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] hist_q [2][HIST_SLOTS];
  logic [SLOT_W-1:0]          wr_pos_q [2];

  audio_out_t filtered_q[$];
  audio_out_t want;

  // Store the sample in its channel history and return the filtered output
  function automatic audio_out_t filter_sample(logic ch, logic signed [SAMPLE_W-1:0] x);
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] rd;
    int unsigned       n;
    longint            acc;
    longint            y;
    audio_out_t        r;
    slot = wr_pos_q[ch];
    hist_q[ch][slot] = x;
    wr_pos_q[ch] = slot + 1'b1;
    n = (taps_q > MAX_TAPS) ? MAX_TAPS : taps_q;
    acc = 0;
    for (int unsigned i = 0; i < n; i++) begin
      rd = slot - SLOT_W'(i);
      acc += longint'(hist_q[ch][rd]) * longint'(coef_q[i]);
    end
    // arithmetic shift floors toward minus infinity
    y = acc >>> FRAC_W;
    r.ch = ch;
    r.clipped = 1'b1;
    if (y > 32767) begin
      r.filtered = 16'sh7fff;
    end else if (y < -32768) begin
      r.filtered = 16'sh8000;
    end else begin
      r.filtered = y[SAMPLE_W-1:0];
      r.clipped = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q = TAPS_RESET;
      for (int unsigned i = 0; i < MAX_TAPS; i++) begin
        coef_q[i] = (i < COEF_ONE_TAPS) ? COEF_ONE : '0;
      end
      for (int c = 0; c < 2; c++) begin
        wr_pos_q[c] = '0;
        for (int s = 0; s < HIST_SLOTS; s++) begin
          hist_q[c][s] = '0;
        end
      end
      filtered_q.delete();
      pending_o = 0;
    end else begin
      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_TAP_COUNT) begin
          taps_q = cfg_data_i[TAP_W-1:0];
        end else begin
          coef_q[cfg_index_i - REG_COEF_0] = cfg_data_i;
        end
      end

      // input request: predict its output
      if (s_tvalid_i && s_tready_i) begin
        filtered_q.insert(filtered_q.size(), filter_sample(s_tuser_i[0], s_tdata_i));
      end

      // output request: compare with the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected output: ch %0d filtered %0d clipped %0d",
                 m_tuser_i[0], $signed(m_tdata_i), m_tuser_i[1]);
          errors_o++;
        end else begin
          want = filtered_q.pop_front();
          checked_o++;
          if (m_tuser_i[1]) clipped_o++;
          if (m_tuser_i[0] !== want.ch) begin
            $error("out_channel: expected %0d, got %0d", want.ch, m_tuser_i[0]);
            errors_o++;
          end
          if (m_tdata_i !== want.filtered) begin
            $error("filtered: expected %0d, got %0d", want.filtered, $signed(m_tdata_i));
            errors_o++;
          end
          if (m_tuser_i[1] !== want.clipped) begin
            $error("clipped: expected %0d, got %0d", want.clipped, m_tuser_i[1]);
            errors_o++;
          end
        end
      end
      pending_o = filtered_q.size();
    end
  end

endmodule

@@ sim/stereo_fir_filter_top_tb.sv @@
// Testbench top for stereo_fir_filter_top: clock, reset, register writes,
// sample stimulus with random gaps and output back-pressure, and the verdict.
// Depends on sfir_pkg, stereo_fir_filter_top and stereo_fir_filter_checker.
`timescale 1ns / 1ps

module stereo_fir_filter_top_tb;
  import sfir_pkg::*;

  localparam int unsigned N_SAMPLES   = 1450;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 24;   // longest item has 7 taps
  localparam longint      LIMIT_NS    = 10_000_000;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [COEF_W-1:0]    cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata  = '0;  // [15:0] sample
  logic [0:0]           s_axis_tuser  = '0;  // [0] channel
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;        // [15:0] filtered
  logic [1:0]           m_axis_tuser;        // [0] out_channel, [1] clipped

  int unsigned errors, pending, checked, clipped;
  int unsigned sent      = 0;
  int unsigned settings  = 0;
  int unsigned hold_req  = 0;
  int unsigned hold_done = 0;

  logic signed [COEF_W-1:0] coef_set [7];

  stereo_fir_filter_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  stereo_fir_filter_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked),
    .clipped_o  (clipped)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 6))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return COEF_ONE;
      3:       return '0;
      4:       return 16'($urandom_range(0, 8191)) - 16'sd4096;
      5:       return 16'($urandom_range(0, 1023)) - 16'sd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int unsigned mode);
    if (mode == 1) return 16'($urandom_range(0, 4095)) - 16'sd2048;
    if (mode == 2 && $urandom_range(0, 1) == 0) begin
      return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
    return 16'($urandom);
  endfunction

  // One register write request
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Write tap count and all seven coefficients from coef_set
  task automatic load_filter(input logic [TAP_W-1:0] taps);
    write_reg(REG_TAP_COUNT, COEF_W'(taps));
    for (int i = 0; i < 7; i++) begin
      write_reg(CFG_IDX_W'(REG_COEF_0 + i), coef_set[i]);
    end
    settings++;
  endtask

  // One sample request, preceded by gap idle cycles
  task automatic send_sample(input logic ch, input logic signed [SAMPLE_W-1:0] x,
                             input int unsigned gap);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    s_axis_tuser  <= ch;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  // Stop offering and wait for every pending output
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
  endtask

  // Output back-pressure: random stalls, quiet stretches, and requested holds
  initial begin
    int unsigned stall_left;
    bit          quiet;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk_i);
        if (hold_req != hold_done) begin
          hold_done++;
          stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39)
                                                   : $urandom_range(0, 2);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [TAP_W-1:0] taps;
    int unsigned      n, ch_mode, smode;
    bit               quiet, hold;
    logic             ch;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings (4 taps of 1.0): short history first, then clipping both ways
    send_sample(1'b0, 16'sh7fff, 0);
    send_sample(1'b1, 16'sh8000, pick_gap());
    send_sample(1'b0, 16'sh7fff, 0);
    send_sample(1'b1, 16'sh8000, pick_gap());
    send_sample(1'b0, 16'sh7fff, 0);
    send_sample(1'b0, 16'sh7fff, 0);
    send_sample(1'b1, -16'sd1, 0);
    send_sample(1'b1, 16'sd1, pick_gap());

    // Tap count zero: output is zero but history still advances
    drain();
    for (int i = 0; i < 7; i++) coef_set[i] = pick_coef();
    load_filter(3'd0);
    send_sample(1'b0, 16'sd12345, 0);
    send_sample(1'b1, -16'sd4321, 0);

    // One tiny tap: floor rounding of negative sums
    drain();
    for (int i = 0; i < 7; i++) coef_set[i] = '0;
    coef_set[0] = 16'sd1;
    load_filter(3'd1);
    send_sample(1'b0, -16'sd1, 0);
    send_sample(1'b1, 16'sd4095, 0);
    send_sample(1'b0, -16'sd4096, 0);
    send_sample(1'b1, -16'sd4097, 0);

    // Seven taps at the most negative coefficient
    drain();
    for (int i = 0; i < 7; i++) coef_set[i] = 16'sh8000;
    load_filter(3'd7);
    send_sample(1'b0, 16'sh8000, 0);
    send_sample(1'b1, 16'sh7fff, 0);
    send_sample(1'b0, 16'sd0, 0);
    send_sample(1'b1, 16'sd0, 0);

    // Seven taps at the most positive coefficient
    drain();
    for (int i = 0; i < 7; i++) coef_set[i] = 16'sh7fff;
    load_filter(3'd7);
    send_sample(1'b0, 16'sh8000, 0);
    send_sample(1'b1, 16'sh7fff, 0);
    send_sample(1'b0, 16'sd1, 0);
    send_sample(1'b1, -16'sd1, 0);

    // Random settings, each followed by a burst of samples
    while (sent < N_SAMPLES) begin
      drain();
      case ($urandom_range(0, 7))
        0:       taps = 3'd0;
        1, 2:    taps = 3'd7;
        default: taps = 3'($urandom_range(1, 6));
      endcase
      for (int i = 0; i < 7; i++) coef_set[i] = pick_coef();
      load_filter(taps);

      quiet   = ($urandom_range(0, 3) == 0);
      ch_mode = $urandom_range(0, 2);
      smode   = $urandom_range(0, 3);
      n       = $urandom_range(30, 90);
      hold    = (settings % 8 == 3);
      if (hold) begin
        // long output stall while samples keep coming, so the input backs up
        @(posedge clk_i);
        hold_req++;
      end
      for (int k = 0; k < n; k++) begin
        case (ch_mode)
          0:       ch = k[0];
          1:       ch = 1'($urandom_range(0, 1));
          default: ch = k[3];
        endcase
        send_sample(ch, pick_sample(smode), (quiet || hold) ? 0 : pick_gap());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d samples on both channels over %0d filter settings", sent, settings);
    $display("(tap counts 0..7, coefficient extremes): %0d outputs checked, %0d saturated.",
             checked, clipped);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/sfir_pkg.sv
rtl/sfir_hist_mem.sv
rtl/sfir_mac.sv
rtl/stereo_fir_filter_top.sv
sim/stereo_fir_filter_checker.sv
sim/stereo_fir_filter_top_tb.sv
